// ===== rtl/adri_pkg.sv =====
package adri_pkg;

  // Queue depth default (the queue logic assumes two entries)
  localparam int QUEUE_DEPTH = 2;

  // Divider operand width (widest operand is the 27-bit system clock)
  localparam int DIV_W = 27;

  localparam int CFG_W  = 27;
  localparam int VFREQ_W = 26;
  localparam int SFREQ_W = 27;

  localparam logic [25:0] VFREQ_RESET = 26'd48681812;
  localparam logic [26:0] SFREQ_RESET = 27'd93750000;
  localparam logic [25:0] FREQ_RESET  = 26'd44100;

  // Configuration register indexes
  localparam logic CFG_VIDEO_FREQ  = 1'b0;
  localparam logic CFG_SYSTEM_FREQ = 1'b1;

  // Bus register indexes (address bits 4:2)
  typedef enum logic [2:0] {
    REG_DMA_ADDR = 3'd0,
    REG_DMA_LEN  = 3'd1,
    REG_ENABLE   = 3'd2,
    REG_IRQ_CLR  = 3'd3,
    REG_RATE     = 3'd4,
    REG_BITRATE  = 3'd5
  } reg_idx_t;

  typedef enum logic {
    DIV_FREQ   = 1'b0,
    DIV_PERIOD = 1'b1
  } div_sel_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DECODE,
    ST_FREQ_DIV,
    ST_PERIOD_GO,
    ST_PERIOD_DIV
  } state_t;

  typedef struct packed {
    logic        command;
    logic [4:0]  address;
    logic [31:0] write_data;
  } cmd_t;

  typedef struct packed {
    logic [31:0] read_data;
    logic        irq_level;
    logic [25:0] dac_frequency;
    logic [26:0] dac_period;
    logic [4:0]  dac_precision;
    logic        frequency_changed;
  } result_t;

  // Controller -> datapath
  typedef struct packed {
    logic     capture;
    logic     div_go;
    div_sel_t div_sel;
    logic     freq_latch;
    logic     commit;
  } ctrl_cmd_t;

  // Datapath -> controller
  typedef struct packed {
    logic is_rate;
    logic div_done;
  } dp_status_t;

endpackage

// ===== rtl/audio_dma_register_interface.sv =====
// Timing: a plain register access is decoded and committed, then its result is registered
//   onto the ports; a rate write (register 4) first runs two bit-serial divisions
//   (frequency, then period) on one shared divider before its commit.
// The block takes no new item while one is in progress (busy is high).
// Reset (rst, synchronous, active high) restores the register file, the configuration and the queue.
// The result strobe lasts one cycle; the receiver cannot stall it.
module audio_dma_register_interface #(
  parameter int QUEUE_DEPTH = adri_pkg::QUEUE_DEPTH
) (
  input  logic                         clk,
  input  logic                         rst,
  // bus access item
  input  logic                         start,
  output logic                         busy,
  input  adri_pkg::cmd_t               cmd,
  // one result item per access
  output logic                         done,
  output adri_pkg::result_t            result,
  // configuration write port (video / system clock frequencies)
  input  logic                         cfg_write,
  input  logic                         cfg_index,
  input  logic [adri_pkg::CFG_W-1:0]   cfg_data
);

  adri_pkg::ctrl_cmd_t  ctl;
  adri_pkg::dp_status_t status;

  // Controller: sequences capture, the two divisions and the final commit.
  adri_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .status (status),
    .ctl    (ctl),
    .busy   (busy)
  );

  // Datapath: register file, DMA queue, divider and result register.
  // A new item can be taken in the cycle its predecessor's result is shown.
  adri_dp #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .ctl       (ctl),
    .status    (status),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .done      (done),
    .result    (result)
  );

endmodule

// ===== rtl/adri_div.sv =====
module adri_div (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         go,
  input  logic [adri_pkg::DIV_W-1:0]   dividend,
  input  logic [adri_pkg::DIV_W-1:0]   divisor,
  output logic                         done,
  output logic [adri_pkg::DIV_W-1:0]   quotient
);

  localparam int W     = adri_pkg::DIV_W;
  localparam int CNT_W = $clog2(W);

  logic [W:0]       rem;
  logic [W-1:0]     quo;
  logic [W-1:0]     dvs;
  logic [CNT_W-1:0] cnt;
  logic             running;

  logic [W:0]       shifted;
  logic             fits;

  // restoring division, one quotient bit per cycle
  assign shifted = {rem[W-1:0], quo[W-1]};
  assign fits    = shifted >= {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done    <= 1'b0;
      cnt     <= '0;
    end else begin
      done <= 1'b0;
      if (go) begin
        running <= 1'b1;
        cnt     <= CNT_W'(W - 1);
      end else if (running) begin
        cnt <= cnt - 1'b1;
        if (cnt == '0) begin
          running <= 1'b0;
          done    <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      rem <= '0;
      quo <= dividend;
      dvs <= divisor;
    end else if (running) begin
      rem <= fits ? shifted - {1'b0, dvs} : shifted;
      quo <= {quo[W-2:0], fits};
    end
  end

  assign quotient = quo;

endmodule

// ===== rtl/adri_ctrl.sv =====
module adri_ctrl (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   start,
  input  adri_pkg::dp_status_t   status,
  output adri_pkg::ctrl_cmd_t    ctl,
  output logic                   busy
);

  adri_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= adri_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      adri_pkg::ST_IDLE: begin
        if (start) state_next = adri_pkg::ST_DECODE;
      end
      adri_pkg::ST_DECODE: begin
        state_next = status.is_rate ? adri_pkg::ST_FREQ_DIV : adri_pkg::ST_IDLE;
      end
      adri_pkg::ST_FREQ_DIV: begin
        if (status.div_done) state_next = adri_pkg::ST_PERIOD_GO;
      end
      adri_pkg::ST_PERIOD_GO: begin
        state_next = adri_pkg::ST_PERIOD_DIV;
      end
      adri_pkg::ST_PERIOD_DIV: begin
        if (status.div_done) state_next = adri_pkg::ST_IDLE;
      end
      default: begin
        state_next = adri_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    ctl        = '0;
    ctl.div_sel = adri_pkg::DIV_FREQ;
    busy       = 1'b1;
    case (state)
      adri_pkg::ST_IDLE: begin
        busy        = 1'b0;
        ctl.capture = start;
      end
      adri_pkg::ST_DECODE: begin
        ctl.div_go = status.is_rate;
        ctl.commit = !status.is_rate;
      end
      adri_pkg::ST_FREQ_DIV: begin
        ctl.freq_latch = status.div_done;
      end
      adri_pkg::ST_PERIOD_GO: begin
        ctl.div_go  = 1'b1;
        ctl.div_sel = adri_pkg::DIV_PERIOD;
      end
      adri_pkg::ST_PERIOD_DIV: begin
        ctl.div_sel = adri_pkg::DIV_PERIOD;
        ctl.commit  = status.div_done;
      end
      default: begin
        busy = 1'b1;
      end
    endcase
  end

endmodule

// ===== rtl/adri_dp.sv =====
module adri_dp #(
  parameter int QUEUE_DEPTH = adri_pkg::QUEUE_DEPTH
) (
  input  logic                         clk,
  input  logic                         rst,
  input  adri_pkg::cmd_t               cmd,
  input  adri_pkg::ctrl_cmd_t          ctl,
  output adri_pkg::dp_status_t         status,
  input  logic                         cfg_write,
  input  logic                         cfg_index,
  input  logic [adri_pkg::CFG_W-1:0]   cfg_data,
  output logic                         done,
  output adri_pkg::result_t            result
);

  localparam int FILL_W = $clog2(QUEUE_DEPTH + 1);
  localparam int IDX_W  = $clog2(QUEUE_DEPTH);
  localparam int DW     = adri_pkg::DIV_W;

  // configuration
  logic [adri_pkg::VFREQ_W-1:0] video_freq;
  logic [adri_pkg::SFREQ_W-1:0] system_freq;

  // captured access
  adri_pkg::cmd_t     cap;
  adri_pkg::reg_idx_t reg_sel;

  // architectural state; queue entries keep only the 8-byte aligned bits
  logic [20:0]       addr_q [QUEUE_DEPTH];
  logic [14:0]       len_q  [QUEUE_DEPTH];
  logic [FILL_W-1:0] fill;
  logic              dma_on;
  logic [13:0]       rate_div;
  logic [3:0]        bit_rate;
  logic [25:0]       cur_freq;
  logic [26:0]       cur_period;
  logic              irq;

  logic [20:0]       addr_q_next [QUEUE_DEPTH];
  logic [14:0]       len_q_next  [QUEUE_DEPTH];
  logic [FILL_W-1:0] fill_next;
  logic              dma_on_next;
  logic [13:0]       rate_div_next;
  logic [3:0]        bit_rate_next;
  logic [25:0]       cur_freq_next;
  logic [26:0]       cur_period_next;
  logic              irq_next;
  logic [31:0]       rd_next;
  logic              changed_next;

  logic [25:0]       new_freq;
  logic [IDX_W-1:0]  slot;
  logic              has_room;
  logic [31:0]       status_word;

  // divider
  logic [DW-1:0] div_dividend;
  logic [DW-1:0] div_divisor;
  logic          div_done;
  logic [DW-1:0] div_q;

  assign reg_sel = adri_pkg::reg_idx_t'(cap.address[4:2]);

  assign status.is_rate  = cap.command && (reg_sel == adri_pkg::REG_RATE);
  assign status.div_done = div_done;

  always_comb begin
    if (ctl.div_sel == adri_pkg::DIV_FREQ) begin
      div_dividend = DW'(video_freq);
      div_divisor  = DW'({1'b0, cap.write_data[13:0]} + 15'd1);
    end else begin
      div_dividend = DW'(system_freq);
      div_divisor  = DW'(new_freq);
    end
  end

  adri_div u_div (
    .clk      (clk),
    .rst      (rst),
    .go       (ctl.div_go),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .done     (div_done),
    .quotient (div_q)
  );

  assign slot     = fill[IDX_W-1:0];
  assign has_room = fill < FILL_W'(QUEUE_DEPTH);

  always_comb begin
    status_word     = 32'h0110_0000;
    status_word[0]  = fill > FILL_W'(1);
    status_word[31] = fill > FILL_W'(1);
    status_word[25] = dma_on;
    status_word[30] = fill > FILL_W'(0);
  end

  always_comb begin
    addr_q_next     = addr_q;
    len_q_next      = len_q;
    fill_next       = fill;
    dma_on_next     = dma_on;
    rate_div_next   = rate_div;
    bit_rate_next   = bit_rate;
    cur_freq_next   = cur_freq;
    cur_period_next = cur_period;
    irq_next        = irq;
    rd_next         = '0;
    changed_next    = 1'b0;
    if (!cap.command) begin
      rd_next = (reg_sel == adri_pkg::REG_IRQ_CLR) ? status_word
                                                   : {14'b0, len_q[0], 3'b000};
    end else begin
      case (reg_sel)
        adri_pkg::REG_DMA_ADDR: begin
          if (has_room) addr_q_next[slot] = cap.write_data[23:3];
        end
        adri_pkg::REG_DMA_LEN: begin
          if (has_room) begin
            if (fill == '0) irq_next = 1'b1;
            len_q_next[slot] = cap.write_data[17:3];
            fill_next        = fill + 1'b1;
          end
        end
        adri_pkg::REG_ENABLE: begin
          dma_on_next = cap.write_data[0];
        end
        adri_pkg::REG_IRQ_CLR: begin
          irq_next = 1'b0;
        end
        adri_pkg::REG_RATE: begin
          rate_div_next   = cap.write_data[13:0];
          cur_freq_next   = new_freq;
          cur_period_next = div_q;
          changed_next    = cur_freq != new_freq;
        end
        adri_pkg::REG_BITRATE: begin
          bit_rate_next = cap.write_data[3:0];
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      video_freq  <= adri_pkg::VFREQ_RESET;
      system_freq <= adri_pkg::SFREQ_RESET;
    end else if (cfg_write) begin
      if (cfg_index == adri_pkg::CFG_VIDEO_FREQ) begin
        video_freq <= cfg_data[adri_pkg::VFREQ_W-1:0];
      end else begin
        system_freq <= cfg_data[adri_pkg::SFREQ_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.capture) cap <= cmd;
    // quotient of video / (rate+1) fits 26 bits; clamp to at least 1
    if (ctl.freq_latch) new_freq <= (div_q == '0) ? 26'd1 : div_q[25:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < QUEUE_DEPTH; i++) begin
        addr_q[i] <= '0;
        len_q[i]  <= '0;
      end
      fill       <= '0;
      dma_on     <= 1'b0;
      rate_div   <= '0;
      bit_rate   <= '0;
      cur_freq   <= adri_pkg::FREQ_RESET;
      cur_period <= '0;
      irq        <= 1'b0;
      done       <= 1'b0;
    end else begin
      done <= ctl.commit;
      if (ctl.commit) begin
        addr_q     <= addr_q_next;
        len_q      <= len_q_next;
        fill       <= fill_next;
        dma_on     <= dma_on_next;
        rate_div   <= rate_div_next;
        bit_rate   <= bit_rate_next;
        cur_freq   <= cur_freq_next;
        cur_period <= cur_period_next;
        irq        <= irq_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.commit) begin
      result.read_data         <= rd_next;
      result.irq_level         <= irq_next;
      result.dac_frequency     <= cur_freq_next;
      result.dac_period        <= cur_period_next;
      result.dac_precision     <= {1'b0, bit_rate_next} + 5'd1;
      result.frequency_changed <= changed_next;
    end
  end

endmodule

// ===== rtl/adri_checker.sv =====
module adri_checker (
  input logic                       clk,
  input logic                       rst,
  input logic                       start,
  input logic                       busy,
  input adri_pkg::cmd_t             cmd,
  input logic                       done,
  input adri_pkg::result_t          result,
  input logic                       cfg_write,
  input logic                       cfg_index,
  input logic [adri_pkg::CFG_W-1:0] cfg_data
);

  // an accepted item keeps the block busy until its result
  assert property (@(posedge clk) disable iff (rst) start && !busy |=> busy)
    else $error("accepted item did not make the block busy");

  // a result closes the work on its item
  assert property (@(posedge clk) disable iff (rst) done |-> !busy && $past(busy))
    else $error("result strobe outside the end of an item");

  // a frequency change only comes from a write, and writes read back zero
  assert property (@(posedge clk) disable iff (rst)
      done && result.frequency_changed |-> result.read_data == 32'd0)
    else $error("frequency change flagged on a read");

  // precision and frequency stay in range
  assert property (@(posedge clk) disable iff (rst)
      done |-> result.dac_precision != 5'd0 && result.dac_precision <= 5'd16
               && result.dac_frequency != 26'd0)
    else $error("precision or frequency out of range");

endmodule

bind audio_dma_register_interface adri_checker u_adri_checker (.*);
